[rtl/assert_macros.svh]
// Assertion helpers for the pose transform block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

[rtl/ept_pkg.sv]
package ept_pkg;
  localparam int AngleBitsDef = 16;
  localparam int CordicSteps = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    r = '0;
    unique case (i)
      0: r = 34'sh20000000; 1: r = 34'sh12E4051E; 2: r = 34'sh09FB385B;
      3: r = 34'sh051111D4; 4: r = 34'sh028B0D43; 5: r = 34'sh0145D7E1;
      6: r = 34'sh00A2F61E; 7: r = 34'sh00517C55; 8: r = 34'sh0028BE53;
      9: r = 34'sh00145F2F; 10: r = 34'sh000A2F98; 11: r = 34'sh000517CC;
      12: r = 34'sh00028BE6; 13: r = 34'sh000145F3; 14: r = 34'sh0000A2FA;
      15: r = 34'sh0000517D; 16: r = 34'sh000028BE; 17: r = 34'sh0000145F;
      18: r = 34'sh00000A30; 19: r = 34'sh00000518; 20: r = 34'sh0000028C;
      21: r = 34'sh00000146; 22: r = 34'sh000000A3; 23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp to [-1, 1] in Q1.14
  function automatic logic signed [15:0] clamp14(input logic signed [40:0] v);
    if (v > 41'sd16384) return 16'sd16384;
    if (v < -41'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  // Q2.28 (or wider) to Q1.14, half up
  function automatic logic signed [15:0] rnd14(input logic signed [32:0] p);
    logic signed [32:0] t;
    t = (p + 33'sd8192) >>> 14;
    return clamp14(41'(t));
  endfunction
endpackage

[rtl/euler_pose_to_transform.sv]
// Pose to transform: pose words in, 3x4 transform words out.
// Input channel: in_valid/in_stall with pos_x/y/z (Q16.16) and three binary
// angles; only the low AngleBits bits of each angle count, so angles wrap.
// Output channel: out_valid/out_stall with m00..m22 (Q1.14, clamped to +-1)
// and t_x/y/z, the translation unchanged.
// R = Rz(angle_about_z) * Ry(angle_about_y) * Rx(angle_about_x).
// Stages: 26 CORDIC stages incl. entry and quadrant fixup, 3 matrix
// stages, 1 output register. Throughput: one word per cycle when not stalled.
// The whole pipe advances as one when the output is free or empty; a
// stall holds every stage, so nothing is lost or repeated. Bubbles are
// not squeezed out: in_stall rises exactly while the output register
// holds a word and out_stall is high, even if earlier stages are empty.
// Reset clears only the valid bits; data registers are not reset.
module euler_pose_to_transform import ept_pkg::*; #(
  parameter int AngleBits = AngleBitsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] pos_x, pos_y, pos_z,
  input  logic [15:0] angle_about_y, angle_about_x, angle_about_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic signed [31:0] t_x, t_y, t_z
);
  `include "assert_macros.svh"
  localparam int Depth = CordicSteps + 2 + 3;

  logic en;
  logic [Depth-1:0] vld;
  logic signed [31:0] tx [Depth], ty [Depth], tz [Depth];
  logic signed [15:0] sy, cy, sx, cx, sz, cz;
  logic signed [15:0] m [9];

  // Pipe moves unless the output holds an untaken word.
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
      out_valid <= vld[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx[0] <= pos_x; ty[0] <= pos_y; tz[0] <= pos_z;
      for (int i = 1; i < Depth; i++) begin
        tx[i] <= tx[i-1]; ty[i] <= ty[i-1]; tz[i] <= tz[i-1];
      end
      t_x <= tx[Depth-1]; t_y <= ty[Depth-1]; t_z <= tz[Depth-1];
      m00 <= m[0]; m01 <= m[1]; m02 <= m[2];
      m10 <= m[3]; m11 <= m[4]; m12 <= m[5];
      m20 <= m[6]; m21 <= m[7]; m22 <= m[8];
    end
  end

  // angle ports are 16 bits; truncate or zero-extend to the angle width
  ept_cordic #(.AngleBits(AngleBits)) u_cy (.clk, .en,
    .ang(AngleBits'(angle_about_y)), .sin_q14(sy), .cos_q14(cy));
  ept_cordic #(.AngleBits(AngleBits)) u_cx (.clk, .en,
    .ang(AngleBits'(angle_about_x)), .sin_q14(sx), .cos_q14(cx));
  ept_cordic #(.AngleBits(AngleBits)) u_cz (.clk, .en,
    .ang(AngleBits'(angle_about_z)), .sin_q14(sz), .cos_q14(cz));

  ept_matrix u_mat (.clk, .en, .sx, .cx, .sy, .cy, .sz, .cz, .m);

  `CHK_IMPL(a_no_stall_empty, clk, rst, in_stall, out_valid)
  `CHK_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid && $stable(t_x))
  `CHK_NEXT(a_vld_move, clk, rst, en && vld[Depth-1], out_valid)
endmodule

[rtl/ept_cordic.sv]
// Pipelined rotation-mode CORDIC, one step per stage; stall freezes all stages.
module ept_cordic import ept_pkg::*; #(
  parameter int AngleBits = AngleBitsDef
) (
  input  logic clk,
  input  logic en,
  input  logic [AngleBits-1:0] ang,
  output logic signed [15:0] sin_q14,
  output logic signed [15:0] cos_q14
);
  logic signed [33:0] xs [CordicSteps+1];
  logic signed [33:0] ys [CordicSteps+1];
  logic signed [33:0] zs [CordicSteps+1];
  logic [1:0] qs [CordicSteps+1];
  logic [31:0] a32;
  logic [31:0] zr;
  logic [1:0] qd;
  logic signed [15:0] c, s;

  assign a32 = {ang, {(32-AngleBits){1'b0}}};
  assign qd = 2'((a32 + 32'h2000_0000) >> 30);
  assign zr = a32 - {qd, 30'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CordicGain;
      ys[0] <= '0;
      zs[0] <= 34'(signed'(zr));
      qs[0] <= qd;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        qs[i+1] <= qs[i];
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q30(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q30(i);
        end
      end
    end
  end

  assign c = clamp14(41'((xs[CordicSteps] + 34'sd32768) >>> 16));
  assign s = clamp14(41'((ys[CordicSteps] + 34'sd32768) >>> 16));

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (qs[CordicSteps])
        2'd0: begin cos_q14 <= c; sin_q14 <= s; end
        2'd1: begin cos_q14 <= -s; sin_q14 <= c; end
        2'd2: begin cos_q14 <= -c; sin_q14 <= -s; end
        default: begin cos_q14 <= s; sin_q14 <= -c; end
      endcase
    end
  end
endmodule

[rtl/ept_matrix.sv]
// Three stages: pair products, triple products, sums and rounding.
module ept_matrix import ept_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic signed [15:0] sx, cx, sy, cy, sz, cz,
  output logic signed [15:0] m [9]
);
  logic signed [15:0] czsy, szsy, s1x, c1x;
  logic signed [15:0] m0, m3, m6, m7, m8;
  logic signed [31:0] p1, p2, p3, p4;

  always_ff @(posedge clk) begin
    if (en) begin
      czsy <= rnd14(33'(cz * sy));
      szsy <= rnd14(33'(sz * sy));
      m0 <= rnd14(33'(cz * cy));
      m3 <= rnd14(33'(sz * cy));
      m6 <= clamp14(-41'(sy));
      m7 <= rnd14(33'(cy * sx));
      m8 <= rnd14(33'(cy * cx));
      s1x <= sx; c1x <= cx;
      p1 <= sz * cx; p2 <= sz * sx; p3 <= cz * cx; p4 <= cz * sx;
    end
  end

  logic signed [31:0] q1, q2, q3, q4, r1, r2, r3, r4;
  logic signed [15:0] n0, n3, n6, n7, n8;
  always_ff @(posedge clk) begin
    if (en) begin
      q1 <= czsy * s1x; q2 <= czsy * c1x; q3 <= szsy * s1x; q4 <= szsy * c1x;
      r1 <= p1; r2 <= p2; r3 <= p3; r4 <= p4;
      n0 <= m0; n3 <= m3; n6 <= m6; n7 <= m7; n8 <= m8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= n0;
      m[1] <= rnd14(33'(q1) - 33'(r1));
      m[2] <= rnd14(33'(q2) + 33'(r2));
      m[3] <= n3;
      m[4] <= rnd14(33'(q3) + 33'(r3));
      m[5] <= rnd14(33'(q4) - 33'(r4));
      m[6] <= n6;
      m[7] <= n7;
      m[8] <= n8;
    end
  end
endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Pose word as queued for the driver
  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic [15:0] ay, ax, az;
  } pose_t;

  // Expected transform word
  typedef struct packed {
    logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] tx, ty, tz;
  } xform_t;

  localparam int AngBits = 16;
  localparam int TrigSteps = 24;
  localparam longint QOne = 16384;
  localparam int PipeDepth = 30;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] angle_about_y = '0, angle_about_x = '0, angle_about_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [31:0] t_x, t_y, t_z;

  euler_pose_to_transform u_top (.*);

  pose_t  pose_q[$];
  xform_t xform_q[$];
  int     mismatches = 0;
  int     cycles = 0;
  int     send_idle_pct = 30;
  int     recv_idle_pct = 70;
  bit     hold_off = 1'b0;
  bit     in_acc = 1'b0;

  // arc tangents as fractions of a turn, Q0.32 (2^32 is one full turn)
  longint arc_tab[TrigSteps] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat_one(longint v);
    if (v > QOne) return QOne;
    if (v < -QOne) return -QOne;
    return v;
  endfunction

  // Q2.28 product -> Q1.14, half up; >>> on longint is a floor
  function automatic longint round_q14(longint p);
    return sat_one((p + 8192) >>> 14);
  endfunction

  // CORDIC sine/cosine after quadrant fold
  function automatic void sin_cos(input logic [15:0] ang, output longint s,
                                  output longint c);
    logic [31:0] a, zz;
    logic [1:0] quad;
    longint x, y, z, dx, dy, cr, sr;
    a = 32'(ang[AngBits-1:0]) << (32 - AngBits);
    zz = a + 32'h20000000;
    quad = zz[31:30];
    zz = a - {quad, 30'd0};
    z = longint'($signed(zz));
    x = 652032874;
    y = 0;
    for (int i = 0; i < TrigSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_tab[i];
      end else begin
        x += dx; y -= dy; z += arc_tab[i];
      end
    end
    cr = sat_one((x + 32768) >>> 16);
    sr = sat_one((y + 32768) >>> 16);
    case (quad)
      2'd0: begin c = cr;  s = sr;  end
      2'd1: begin c = -sr; s = cr;  end
      2'd2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endfunction

  function automatic xform_t pose_to_xform(pose_t p);
    longint sy, cy, sx, cx, sz, cz, czsy, szsy;
    xform_t r;
    sin_cos(p.ay, sy, cy);
    sin_cos(p.ax, sx, cx);
    sin_cos(p.az, sz, cz);
    czsy = round_q14(cz * sy);
    szsy = round_q14(sz * sy);
    r.r00 = 16'(round_q14(cz * cy));
    r.r01 = 16'(round_q14(czsy * sx - sz * cx));
    r.r02 = 16'(round_q14(czsy * cx + sz * sx));
    r.r10 = 16'(round_q14(sz * cy));
    r.r11 = 16'(round_q14(szsy * sx + cz * cx));
    r.r12 = 16'(round_q14(szsy * cx - cz * sx));
    r.r20 = 16'(sat_one(-sy));
    r.r21 = 16'(round_q14(cy * sx));
    r.r22 = 16'(round_q14(cy * cx));
    r.tx = p.px; r.ty = p.py; r.tz = p.pz;
    return r;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 65536)) - 32'd32768;
      default: return $urandom;
    endcase
  endfunction

  // angles: mostly random, some near quadrant and octant boundaries
  function automatic logic [15:0] rand_ang();
    if ($urandom_range(0, 3) == 0)
      return 16'({$urandom_range(0, 7), 13'd0} + $urandom_range(0, 4) - 2);
    return 16'($urandom);
  endfunction

  task automatic push_pose(logic [31:0] px, py, pz, logic [15:0] ay, ax, az);
    pose_t p;
    p.px = px; p.py = py; p.pz = pz;
    p.ay = ay; p.ax = ax; p.az = az;
    pose_q.push_back(p);
  endtask

  // Driver: next word presented at the falling edge; held until taken
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_acc) begin
        // payload held
      end else if (!hold_off && pose_q.size() > 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        pos_x         <= pose_q[0].px;
        pos_y         <= pose_q[0].py;
        pos_z         <= pose_q[0].pz;
        angle_about_y <= pose_q[0].ay;
        angle_about_x <= pose_q[0].ax;
        angle_about_z <= pose_q[0].az;
        void'(pose_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    xform_t got, want;
    cycles <= cycles + 1;
    in_acc = in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        xform_q.push_back(pose_to_xform({pos_x, pos_y, pos_z,
                                         angle_about_y, angle_about_x, angle_about_z}));
      if (out_valid && !out_stall) begin
        got = {m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z};
        if (xform_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word %h", got);
        end else begin
          want = xform_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h, actual %h", want, got);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Fill the pose queue per phase and wait for it to drain
  task automatic run_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++)
      push_pose(rand_pos(), rand_pos(), rand_pos(), rand_ang(), rand_ang(), rand_ang());
    while (pose_q.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    // directed: zero pose, axis turns, wrap-around, extremes of translation
    push_pose(0, 0, 0, 0, 0, 0);
    push_pose(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_pose(32'h80000000, 32'h7FFFFFFF, 32'h00010000, 16'h4000, 0, 0);
    push_pose(1, 2, 3, 0, 16'h4000, 0);
    push_pose(4, 5, 6, 0, 0, 16'h4000);
    push_pose(7, 8, 9, 16'h8000, 16'h8000, 16'h8000);
    push_pose(0, 0, 0, 16'hC000, 16'hC000, 16'hC000);
    push_pose(0, 0, 0, 16'h2000, 16'h2000, 16'h2000);
    push_pose(0, 0, 0, 16'hE000, 16'h6000, 16'hA000);
    push_pose(0, 0, 0, 16'h1FFF, 16'h3FFF, 16'h4001);
    push_pose(0, 0, 0, 16'h5555, 16'hAAAA, 16'h0001);
    push_pose(32'hAAAAAAAA, 32'h55555555, 32'h12345678, 16'h7FFF, 16'h8001, 16'hBFFF);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_phase(500, 30, 70);
    // drain fully with the sender held off
    hold_off = 1'b1;
    while (xform_q.size() > 0) @(posedge clk);
    hold_off = 1'b0;
    run_phase(500, 70, 30);
    run_phase(200, 0, 0);
    while (xform_q.size() > 0) @(posedge clk);
    repeat (PipeDepth + 10) @(posedge clk);
    if (mismatches == 0 && xform_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
